// ===== rtl/mmed_pkg.sv =====
// Shared constants and types for the multichannel moving median filter.
// No dependencies; imported by mmed_store, multichannel_moving_median and the bench.
package mmed_pkg;

    localparam int CHANNELS     = 16;
    localparam int MAX_WINDOW   = 64;
    localparam int DATA_W       = 32;
    localparam int LEN_W        = 6;
    localparam int CH_W         = $clog2(CHANNELS);
    localparam int POS_W        = $clog2(MAX_WINDOW);
    localparam int CNT_W        = $clog2(MAX_WINDOW + 1);
    localparam int ADDR_W       = CH_W + POS_W;
    localparam int DEPTH        = CHANNELS * MAX_WINDOW;

    localparam logic [LEN_W-1:0] WINDOW_RESET = LEN_W'(20);

    typedef logic signed [DATA_W-1:0] t_sample;
    typedef logic [ADDR_W-1:0]        t_addr;

    // write request into the sample store
    typedef struct packed {
        logic    en;
        t_addr   addr;
        t_sample data;
    } t_store_wr;

endpackage

// ===== rtl/mmed_store.sv =====
// Sample store: one-write, one-read memory with registered read data and a
// zeroing sweep after reset. Depends on mmed_pkg.
module mmed_store
    import mmed_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_store_wr i_wr,
    input  t_addr     i_raddr,
    output t_sample   o_rdata,
    output logic      o_busy
);

    t_sample r_mem [DEPTH];
    t_sample r_rdata;
    t_addr   r_clr_addr;
    logic    r_clr_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == t_addr'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // zero one entry a cycle while sweeping, otherwise take the write request
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_clr_busy;

endmodule

// ===== rtl/multichannel_moving_median.sv =====
// Multichannel moving median: per-channel ring of samples, median by rank search.
// Depends on mmed_pkg and mmed_store.
//
// Each input beat carries a channel and a signed Q16.16 sample; the sample goes
// into the channel's window slot after the last one written (wrapping at the
// window length, so the first sample lands in slot 1) and one output beat
// returns entry window_len/2 of the sorted window. The median is found with a
// signed less-than and less-or-equal compare stepping over the single read port
// of the sample store: each candidate slot is read once and ranked against all
// n window entries until the candidate whose rank covers n/2 is met, n being
// the effective window length (0 counts as 1). One item is processed at a time.
// After reset the store is swept to zero, one entry per cycle over all 1024
// entries; input beats are refused until then, while window_len writes are
// taken at any time.
module multichannel_moving_median
    import mmed_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // slave side: [3:0] channel, [35:4] sample, [39:36] zero
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [39:0]       i_s_axis_tdata,
    // master side: [31:0] median
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [31:0]       o_m_axis_tdata,
    // window length register
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [LEN_W-1:0]  i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_LATCH,
        S_SCAN,
        S_DONE
    } t_state;

    t_state             r_state;
    logic [LEN_W-1:0]   r_window_len;
    logic [POS_W-1:0]   r_wp [CHANNELS];
    logic [CH_W-1:0]    r_ch;
    logic [CNT_W-1:0]   r_n;
    logic [CNT_W-1:0]   r_c;
    logic [CNT_W-1:0]   r_j;
    logic [CNT_W-1:0]   r_lt;
    logic [CNT_W-1:0]   r_le;
    t_sample            r_cand;
    logic               r_m_valid;
    t_sample            r_m_data;

    logic               store_busy;
    t_sample            rdata;
    t_store_wr          wr;
    t_addr              raddr;
    logic               in_accept;
    logic [CH_W-1:0]    in_ch;
    t_sample            in_sample;
    logic [CNT_W-1:0]   eff_n;
    logic [CNT_W-1:0]   pos_inc;
    logic [POS_W-1:0]   new_pos;
    logic [CNT_W-1:0]   rd_idx;
    logic [CNT_W-1:0]   k;
    logic [CNT_W-1:0]   n_lt;
    logic [CNT_W-1:0]   n_le;
    logic               last_cmp;
    logic               hit;

    assign in_ch     = i_s_axis_tdata[CH_W-1:0];
    assign in_sample = t_sample'(i_s_axis_tdata[CH_W +: DATA_W]);

    assign o_s_axis_tready = (r_state == S_IDLE) && !store_busy;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    // effective window: zero acts as one, saturate at MAX_WINDOW
    always_comb begin
        if (r_window_len == '0) begin
            eff_n = CNT_W'(1);
        end else if (32'(r_window_len) > MAX_WINDOW) begin
            eff_n = CNT_W'(MAX_WINDOW);
        end else begin
            eff_n = CNT_W'(r_window_len);
        end
    end

    // advance the write position, wrapping at the window length
    always_comb begin
        pos_inc = CNT_W'(r_wp[in_ch]) + CNT_W'(1);
        if (pos_inc >= eff_n) begin
            new_pos = '0;
        end else begin
            new_pos = pos_inc[POS_W-1:0];
        end
    end

    assign wr.en   = in_accept;
    assign wr.addr = {in_ch, new_pos};
    assign wr.data = in_sample;

    always_comb begin
        case (r_state)
            S_LOAD:  rd_idx = r_c;
            S_LATCH: rd_idx = '0;
            S_SCAN:  rd_idx = r_j + CNT_W'(1);
            default: rd_idx = '0;
        endcase
    end

    assign raddr = {r_ch, rd_idx[POS_W-1:0]};

    // rank the candidate against the element read back this cycle
    assign k        = r_n >> 1;
    assign n_lt     = r_lt + CNT_W'(rdata < r_cand);
    assign n_le     = r_le + CNT_W'(rdata <= r_cand);
    assign last_cmp = (r_j == r_n - CNT_W'(1));
    assign hit      = (n_lt <= k) && (k < n_le);

    mmed_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_raddr (raddr),
        .o_rdata (rdata),
        .o_busy  (store_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_window_len <= WINDOW_RESET;
            r_m_valid    <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_wp[i] <= '0;
            end
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_window_len <= i_cfg_data;
            end
            // S_DONE decides the output valid itself
            if (r_m_valid && i_m_axis_tready && r_state != S_DONE) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_wp[in_ch] <= new_pos;
                        r_ch        <= in_ch;
                        r_n         <= eff_n;
                        r_c         <= '0;
                        r_state     <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_state <= S_LATCH;
                end
                S_LATCH: begin
                    r_cand  <= rdata;
                    r_lt    <= '0;
                    r_le    <= '0;
                    r_j     <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    r_lt <= n_lt;
                    r_le <= n_le;
                    r_j  <= r_j + CNT_W'(1);
                    if (last_cmp) begin
                        if (hit) begin
                            r_state <= S_DONE;
                        end else begin
                            r_c     <= r_c + CNT_W'(1);
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (!r_m_valid || i_m_axis_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= r_cand;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

    // no beat is taken while the previous one is still being ranked
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input accepted while busy");

    // the rank search must end before running past the window
    a_cand_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> (r_c < r_n))
        else $error("median candidate outside window");

    // strict count never exceeds the inclusive count
    a_rank_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_lt <= r_le))
        else $error("rank counters out of order");

endmodule

// ===== bench/mmed_median_checker.sv =====
// Checker for multichannel_moving_median: watches the input, output and window-length
// channels, predicts each median and compares it with the output beats.
// Depends on mmed_pkg; instantiated beside the block by multichannel_moving_median_tb.
module mmed_median_checker
    import mmed_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [39:0]       i_in_data,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [31:0]       i_out_data,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [LEN_W-1:0]  i_cfg_data,
    output int                o_failures,
    output int                o_pending
);

    localparam logic [LEN_W-1:0] RESET_WINDOW = LEN_W'(20);

    t_sample          window_store [CHANNELS][MAX_WINDOW];
    logic [POS_W-1:0] last_slot [CHANNELS];
    logic [LEN_W-1:0] window_len;
    t_sample          expected_medians [$];
    int               failures = 0;

    // write the sample into the channel's ring, then pick entry n/2 of the sorted window
    function automatic t_sample insert_and_select(input logic [CH_W-1:0] ch, input t_sample smp);
        t_sample sorted [MAX_WINDOW];
        t_sample v;
        int n;
        int slot;
        int j;
        n = (window_len == '0) ? 1 : int'(window_len);
        if (n > MAX_WINDOW)
            n = MAX_WINDOW;
        slot = int'(last_slot[ch]) + 1;
        // wrap also when the window has shrunk below the last slot
        if (slot >= n)
            slot = 0;
        last_slot[ch] = POS_W'(slot);
        window_store[ch][slot] = smp;
        for (int i = 0; i < n; i++)
            sorted[i] = window_store[ch][i];
        for (int i = 1; i < n; i++) begin
            v = sorted[i];
            j = i;
            while (j > 0 && sorted[j-1] > v) begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = v;
        end
        return sorted[n/2];
    endfunction

    always @(posedge i_clk) begin
        t_sample want;
        if (!i_rst_n) begin
            window_len = RESET_WINDOW;
            for (int c = 0; c < CHANNELS; c++) begin
                last_slot[c] = '0;
                for (int s = 0; s < MAX_WINDOW; s++)
                    window_store[c][s] = '0;
            end
            expected_medians.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_medians.size() == 0) begin
                    $error("median: beat %0d arrived with nothing expected", t_sample'(i_out_data));
                    failures++;
                end else begin
                    want = expected_medians.pop_front();
                    if (t_sample'(i_out_data) !== want) begin
                        $error("median mismatch: expected %0d, actual %0d",
                               want, t_sample'(i_out_data));
                        failures++;
                    end
                end
            end
            // a beat taken on the same edge as a window write still sees the old length
            if (i_in_valid && i_in_ready)
                expected_medians.push_back(insert_and_select(i_in_data[CH_W-1:0],
                                                             i_in_data[CH_W +: DATA_W]));
            if (i_cfg_valid && i_cfg_ready)
                window_len = i_cfg_data;
        end
        // publish after the edge so the stimulus sees a settled count
        o_failures <= failures;
        o_pending  <= expected_medians.size();
    end

endmodule

// ===== bench/multichannel_moving_median_tb.sv =====
// Top of the multichannel_moving_median bench: clock, reset, sample and window-length
// stimulus, output back-pressure, watchdog and verdict. Depends on mmed_pkg, the block
// and mmed_median_checker.
module multichannel_moving_median_tb
    import mmed_pkg::*;
();

    typedef enum int {RX_ALWAYS, RX_HALF, RX_SPARSE, RX_MOSTLY} t_rx_mode;

    localparam int NUM_PHASES     = 12;
    localparam int WIDEST_WINDOW  = 63;
    localparam int PHASE_ITEMS    = 90;
    localparam int WIDE_ITEMS     = 70;
    localparam int LONG_HOLD      = 400;
    localparam int SETTLE_CYCLES  = 200;
    // slowest item plus a long hold and the post-reset sweep, with margin
    localparam int WATCHDOG_LIMIT = 20000;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    logic [39:0]      s_data    = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    logic [31:0]      m_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [LEN_W-1:0] cfg_data  = '0;

    int failures;
    int pending;
    int idle_cycles     = 0;
    int hold_off_asked  = 0;
    int hold_off_served = 0;

    multichannel_moving_median dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    mmed_median_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (s_valid),
        .i_in_ready  (s_ready),
        .i_in_data   (s_data),
        .i_out_valid (m_valid),
        .i_out_ready (m_ready),
        .i_out_data  (m_data),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .o_failures  (failures),
        .o_pending   (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic int window_for_phase(input int p);
        case (p)
            0:       return 3;
            1:       return 5;
            2:       return 1;
            3:       return 8;
            4:       return 0;
            5:       return 13;
            6:       return 2;
            7:       return 20;
            8:       return WIDEST_WINDOW;
            9:       return 4;
            10:      return 6;
            default: return 9;
        endcase
    endfunction

    // mix of wide random words, clustered small values, extremes and Q16.16 integers
    function automatic t_sample pick_sample();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 4)
            return t_sample'($urandom);
        if (roll < 7)
            return t_sample'(int'($urandom_range(0, 16)) - 8);
        if (roll < 8) begin
            case ($urandom_range(0, 3))
                0:       return 32'sh7FFFFFFF;
                1:       return 32'sh80000000;
                2:       return '0;
                default: return '1;
            endcase
        end
        return t_sample'((int'($urandom_range(0, 40)) - 20) * 65536);
    endfunction

    // leave valid high on return so back-to-back beats need no extra edge
    task automatic send_sample(input logic [CH_W-1:0] ch, input t_sample smp);
        s_valid <= 1'b1;
        s_data  <= {4'b0000, smp, ch};
        @(posedge clk);
        while (!s_ready)
            @(posedge clk);
    endtask

    task automatic pause_sender(input int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_window(input int len);
        cfg_valid <= 1'b1;
        cfg_data  <= LEN_W'(len);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int count, input bit squeeze);
        logic [CH_W-1:0] hot_a;
        logic [CH_W-1:0] hot_b;
        logic [CH_W-1:0] ch;
        int burst;
        hot_a = CH_W'($urandom_range(0, CHANNELS - 1));
        hot_b = CH_W'($urandom_range(0, CHANNELS - 1));
        burst = 0;
        for (int i = 0; i < count; i++) begin
            if (burst == 0) begin
                pause_sender($urandom_range(1, ($urandom_range(0, 7) == 0) ? 60 : 8));
                burst = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                    : $urandom_range(1, 12);
            end
            // ask the receiver for a long hold while beats keep coming
            if (squeeze && i == count / 3)
                hold_off_asked++;
            // keep most beats on two channels so their windows fill with real data
            if ($urandom_range(0, 3) == 0)
                ch = CH_W'($urandom_range(0, CHANNELS - 1));
            else
                ch = ($urandom_range(0, 1) == 0) ? hot_a : hot_b;
            send_sample(ch, pick_sample());
            burst--;
        end
        drain();
    endtask

    initial begin : receiver
        t_rx_mode mode;
        int seg_left;
        int hold_left;
        mode      = RX_ALWAYS;
        seg_left  = 0;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (hold_off_served != hold_off_asked) begin
                hold_off_served = hold_off_asked;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    mode     = t_rx_mode'($urandom_range(0, 3));
                    seg_left = $urandom_range(20, 200);
                end
                seg_left--;
                case (mode)
                    RX_ALWAYS: m_ready <= 1'b1;
                    RX_HALF:   m_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                    default:   m_ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    always @(posedge clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset window of 20: early windows are mostly zeros
        send_sample(4'd0, 32'sh7FFFFFFF);
        send_sample(4'd15, 32'sh80000000);
        send_sample(4'd3, 32'sd5);
        send_sample(4'd3, -32'sd5);
        send_sample(4'd3, 32'sh7FFFFFFF);
        send_sample(4'd3, 32'sh80000000);
        send_sample(4'd3, '0);
        send_sample(4'd3, 32'sd3);
        drain();

        // shrink the window below the last slot written on channel 3
        write_window(2);
        send_sample(4'd3, 32'sd11);
        send_sample(4'd3, -32'sd11);
        send_sample(4'd0, -32'sd1);
        drain();

        // zero length behaves as a window of one
        write_window(0);
        send_sample(4'd5, -32'sd7);
        send_sample(4'd5, 32'sd9);
        drain();

        write_window(1);
        send_sample(4'd5, 32'sh80000000);
        send_sample(4'd5, 32'sh7FFFFFFF);
        drain();

        write_window(WIDEST_WINDOW);
        send_sample(4'd7, 32'sd100);
        send_sample(4'd7, -32'sd100);
        send_sample(4'd7, 32'sh7FFFFFFF);
        send_sample(4'd7, 32'sh80000000);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_window(window_for_phase(p));
            run_phase((window_for_phase(p) == WIDEST_WINDOW) ? WIDE_ITEMS : PHASE_ITEMS,
                      p == 1 || p == 7);
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (failures == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/mmed_pkg.sv
rtl/mmed_store.sv
rtl/multichannel_moving_median.sv
bench/mmed_median_checker.sv
bench/multichannel_moving_median_tb.sv
